FILE: src/pctfix_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctfix_pkg
// Shared types, character codes and helper functions for the percent escape
// fixup block.
// ----------------------------------------------------------------------------
package pctfix_pkg;

    localparam int HOLD_DEPTH    = 5;
    localparam int PAT_LEN       = 6;
    localparam int JOB_DEPTH_DEF = 4;

    localparam logic [7:0] VALUE_OFFSET = 8'h40;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0f;

    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_8      = 8'h38;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UB     = 8'h42;
    localparam logic [7:0] CH_UC     = 8'h43;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LC     = 8'h63;
    localparam logic [7:0] CH_LF     = 8'h66;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [PAT_LEN-1:0][7:0] data;
        logic [2:0]              cnt;
        logic                    last;
    } t_job;

    function automatic logic is_hex(input t_byte c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input t_byte c);
        logic [7:0] r;
        r = 8'h00;
        if (c >= CH_0 && c <= CH_9) begin
            r = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LF) begin
            r = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = c - CH_UA + 8'd10;
        end
        return r[3:0];
    endfunction

    function automatic t_byte hex_char(input logic [3:0] v);
        t_byte r;
        if (v < 4'd10) begin
            r = CH_0 + {4'h0, v};
        end else begin
            r = CH_UA + {4'h0, v} - 8'd10;
        end
        return r;
    endfunction

    // pattern position check
    function automatic logic fits_at(input logic [2:0] pos, input t_byte c);
        logic r;
        unique case (pos)
            3'd0:    r = (c == CH_PCT);
            3'd1:    r = (c == CH_UC) || (c == CH_LC);
            3'd2:    r = (c == CH_3);
            3'd3:    r = (c == CH_PCT);
            3'd4:    r = c inside {CH_8, CH_9, CH_UA, CH_UB, CH_LA, CH_LB};
            3'd5:    r = is_hex(c);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/percent_utf8_to_latin1_fixup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// percent_utf8_to_latin1_fixup
// Rewrites "%C3%XY" escapes to single Latin-1 escapes in a byte stream.
// ----------------------------------------------------------------------------
// path: an input's results pass the job queue, then the output register
// throughput: one input byte per cycle unless o_full; the output register
//   drains one byte per cycle while popped, one byte per result of an input
// reset: synchronous active low; clears the held prefix count, the job
//   queue and the output register's valid flag
module percent_utf8_to_latin1_fixup #(
    parameter int JOB_DEPTH = pctfix_pkg::JOB_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);
    import pctfix_pkg::*;

    logic w_accept;
    logic w_job_valid;
    t_job w_job;
    logic w_q_empty;
    t_job w_head;
    logic w_done;

    assign w_accept = i_push && !o_full;

    pctfix_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_in_byte),
        .i_last      (i_in_last),
        .o_job_valid (w_job_valid),
        .o_job       (w_job)
    );

    pctfix_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_job_valid),
        .i_wr_job (w_job),
        .i_rd     (w_done),
        .o_full   (o_full),
        .o_empty  (w_q_empty),
        .o_head   (w_head)
    );

    pctfix_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_q_empty),
        .i_job       (w_head),
        .o_job_done  (w_done),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_byte      (o_out_byte),
        .o_last      (o_out_last)
    );

endmodule
`default_nettype wire

FILE: src/pctfix_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctfix_front
// Holds the pending pattern prefix, classifies each accepted byte and builds
// one job of up to six output bytes.
// ----------------------------------------------------------------------------
module pctfix_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    output logic                  o_job_valid,
    output pctfix_pkg::t_job      o_job
);
    import pctfix_pkg::*;

    t_byte                   r_hold [HOLD_DEPTH];
    t_byte                   n_hold [HOLD_DEPTH];
    logic [2:0]              r_cnt;
    logic [2:0]              n_cnt;

    logic [PAT_LEN-1:0][7:0] w_buf;
    logic [PAT_LEN-1:0]      w_ok;
    logic [2:0]              w_len;
    logic [2:0]              w_sel;
    logic [7:0]              w_val;
    logic                    w_match;

    always_comb begin
        for (int i = 0; i < PAT_LEN; i++) begin
            if (i < HOLD_DEPTH && 3'(i) < r_cnt) begin
                w_buf[i] = r_hold[i];
            end else begin
                w_buf[i] = i_byte;
            end
        end
        w_len = r_cnt + 3'd1;

        // prefix check for every start offset
        for (int j = 0; j < PAT_LEN; j++) begin
            w_ok[j] = 1'b1;
            for (int i = 0; i < PAT_LEN; i++) begin
                if (j + i < PAT_LEN) begin
                    if (3'(j + i) <= r_cnt) begin
                        w_ok[j] = w_ok[j] & fits_at(3'(i), w_buf[j + i]);
                    end
                end
            end
        end

        w_sel = w_len;
        for (int j = PAT_LEN - 1; j >= 0; j--) begin
            if (w_ok[j] && 3'(j) <= r_cnt) begin
                w_sel = 3'(j);
            end
        end

        w_match = (w_sel == 3'd0) && (r_cnt == 3'(HOLD_DEPTH));
        w_val   = {hex_val(w_buf[4]), hex_val(w_buf[5])} + VALUE_OFFSET;

        o_job.data = w_buf;
        o_job.last = i_last;
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            n_hold[i] = r_hold[i];
        end

        if (w_match) begin
            o_job.data[0] = CH_PCT;
            o_job.data[1] = hex_char(4'((w_val >> 4) & NIBBLE_MASK));
            o_job.data[2] = hex_char(4'(w_val & NIBBLE_MASK));
            o_job.cnt     = 3'd3;
            n_cnt         = 3'd0;
        end else if (i_last) begin
            o_job.cnt = w_len;
            n_cnt     = 3'd0;
        end else begin
            o_job.cnt = w_sel;
            n_cnt     = w_len - w_sel;
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                for (int s = 0; s < PAT_LEN; s++) begin
                    if (i + s < PAT_LEN) begin
                        if (w_sel == 3'(s)) begin
                            n_hold[i] = w_buf[i + s];
                        end
                    end
                end
            end
        end

        o_job_valid = i_accept && (o_job.cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                r_hold[i] <= n_hold[i];
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/pctfix_jobq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctfix_jobq
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module pctfix_jobq #(
    parameter int DEPTH = pctfix_pkg::JOB_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire pctfix_pkg::t_job i_wr_job,
    input  wire logic             i_rd,
    output logic                  o_full,
    output logic                  o_empty,
    output pctfix_pkg::t_job      o_head
);
    import pctfix_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= next_ptr(r_wr);
            end
            if (w_rd) begin
                r_rd <= next_ptr(r_rd);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_wr_job;
        end
    end

endmodule
`default_nettype wire

FILE: src/pctfix_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctfix_back
// Walks the bytes of the head job into the output register, one per cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
module pctfix_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  wire pctfix_pkg::t_job i_job,
    output logic                  o_job_done,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_byte,
    output logic                  o_last
);
    import pctfix_pkg::*;

    logic [2:0] r_idx;
    logic       r_ov;
    t_byte      r_ob;
    logic       r_ol;
    logic       w_load;
    logic       w_end;

    assign o_empty    = !r_ov;
    assign o_byte     = r_ob;
    assign o_last     = r_ol;
    assign w_load     = i_job_valid && (!r_ov || i_pop);
    assign w_end      = (r_idx == (i_job.cnt - 3'd1));
    assign o_job_done = w_load && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_ov  <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= w_end ? 3'd0 : r_idx + 3'd1;
                r_ov  <= 1'b1;
            end else if (i_pop) begin
                r_ov  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ob <= i_job.data[r_idx];
            r_ol <= i_job.last && w_end;
        end
    end

endmodule
`default_nettype wire
